>>> design/urdc8_pkg.sv
// constants, codes and the crc-8 step shared by the uart register datagram block
// no dependencies; the top level and the testbench refer to it by scoped names
package urdc8_pkg;

    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_RX_BYTE = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    localparam logic KIND_TX    = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

    localparam logic REG_NODE_ADDRESS  = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    localparam logic [7:0]  SYNC_BYTE        = 8'h05;
    localparam logic [7:0]  CRC_POLY         = 8'h07;
    localparam logic [7:0]  WRITE_FLAG       = 8'h80;
    localparam logic [31:0] ERROR_WORD       = 32'hFFFF_FFFF;
    localparam logic [15:0] WAIT_MAX         = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET    = 16'd50;
    localparam logic [2:0]  LAST_BYTE_IDX    = 3'd7;
    localparam logic [3:0]  REPLY_CRC_IDX    = 4'd7;
    localparam logic [3:0]  REPLY_DATA_START = 4'd3;

    // one byte of crc-8, msb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> design/urdc8_req_if.sv
// request channel: register requests, received bytes and timer ticks
// no dependencies
interface urdc8_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic        is_write;
    logic [6:0]  reg_address;
    logic [31:0] write_data;
    logic [7:0]  rx_byte;

    modport source (output valid, op, is_write, reg_address, write_data, rx_byte,
                    input ready);
    modport sink   (input valid, op, is_write, reg_address, write_data, rx_byte,
                    output ready);
endinterface

>>> design/urdc8_rsp_if.sv
// result channel: datagram bytes and read reply outcomes
// no dependencies
interface urdc8_rsp_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [31:0] read_data;
    logic [1:0]  status;

    modport source (output valid, kind, tx_byte, last, read_data, status,
                    input ready);
    modport sink   (input valid, kind, tx_byte, last, read_data, status,
                    output ready);
endinterface

>>> design/urdc8_cfg_if.sv
// configuration write channel: register index and write data
// no dependencies
interface urdc8_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/uart_register_datagram_crc8_unit.sv
// uart register datagram master with crc-8: input register, datagram byte
// sequencer, reply collector and output register; uses urdc8_pkg and the channel interfaces
// the first result word passes through the input register and then the output register
// a register request holds the input register until all eight of its datagram bytes
// have gone out; a received byte or tick leaves it on its first advance
// output register stalls hold the input register; a new word is taken as the old one leaves
// reset: asynchronous, clears channels, reply state, node address 0, timeout 50 ticks
module uart_register_datagram_crc8_unit (
    input  logic        clk,
    input  logic        rst_n,
    urdc8_req_if.sink   req,
    urdc8_rsp_if.source rsp,
    urdc8_cfg_if.sink   cfg
);

    // configuration
    logic [7:0]  node_address_reg;
    logic [15:0] timeout_ticks_reg;

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [1:0]  in_op_reg;
    logic        in_is_write_reg;
    logic [6:0]  in_reg_address_reg;
    logic [31:0] in_write_data_reg;
    logic [7:0]  in_rx_byte_reg;

    // datagram sequencer
    logic [2:0]  byte_idx_reg, byte_idx_next;
    logic [7:0]  tx_crc_reg, tx_crc_next;

    // reply state
    logic        reply_armed_reg, reply_armed_next;
    logic [3:0]  reply_count_reg, reply_count_next;
    logic [7:0]  reply_crc_reg, reply_crc_next;
    logic [31:0] reply_word_reg, reply_word_next;
    logic [15:0] wait_count_reg, wait_count_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [7:0]  out_tx_byte_reg, out_tx_byte_next;
    logic        out_last_reg, out_last_next;
    logic [31:0] out_read_data_reg, out_read_data_next;
    logic [1:0]  out_status_reg, out_status_next;

    logic        accept;
    logic        advance;
    logic        consume;
    logic        emit;
    logic [31:0] dg_data;
    logic [7:0]  dg_byte;
    logic [15:0] wait_inc;

    assign advance = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign consume = advance && ((in_op_reg != urdc8_pkg::OP_REQUEST)
                                 || (byte_idx_reg == urdc8_pkg::LAST_BYTE_IDX));
    assign req.ready = !in_valid_reg || consume;
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    // data bytes of a read datagram go out as zero
    assign dg_data  = in_is_write_reg ? in_write_data_reg : 32'd0;
    assign wait_inc = (wait_count_reg != urdc8_pkg::WAIT_MAX) ? wait_count_reg + 16'd1
                                                               : wait_count_reg;

    always_comb
    begin
        unique case (byte_idx_reg)
            3'd0:    dg_byte = urdc8_pkg::SYNC_BYTE;
            3'd1:    dg_byte = node_address_reg;
            3'd2:    dg_byte = {in_is_write_reg, in_reg_address_reg};
            3'd3:    dg_byte = dg_data[31:24];
            3'd4:    dg_byte = dg_data[23:16];
            3'd5:    dg_byte = dg_data[15:8];
            3'd6:    dg_byte = dg_data[7:0];
            default: dg_byte = tx_crc_reg;
        endcase
    end

    always_comb
    begin
        in_valid_next      = in_valid_reg;
        byte_idx_next      = byte_idx_reg;
        tx_crc_next        = tx_crc_reg;
        reply_armed_next   = reply_armed_reg;
        reply_count_next   = reply_count_reg;
        reply_crc_next     = reply_crc_reg;
        reply_word_next    = reply_word_reg;
        wait_count_next    = wait_count_reg;
        emit               = 1'b0;
        out_kind_next      = urdc8_pkg::KIND_TX;
        out_tx_byte_next   = 8'd0;
        out_last_next      = 1'b0;
        out_read_data_next = 32'd0;
        out_status_next    = urdc8_pkg::STATUS_OK;

        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end

        if (advance)
        begin
            priority case (in_op_reg)
                urdc8_pkg::OP_REQUEST:
                begin
                    emit             = 1'b1;
                    out_tx_byte_next = dg_byte;
                    out_last_next    = (byte_idx_reg == urdc8_pkg::LAST_BYTE_IDX);
                    byte_idx_next    = byte_idx_reg + 3'd1;
                    tx_crc_next      = urdc8_pkg::crc8_byte(
                        (byte_idx_reg == 3'd0) ? 8'd0 : tx_crc_reg, dg_byte);
                    // a read arms reception once its datagram is out
                    if ((byte_idx_reg == urdc8_pkg::LAST_BYTE_IDX) && !in_is_write_reg)
                    begin
                        reply_armed_next = 1'b1;
                        reply_count_next = 4'd0;
                        reply_crc_next   = 8'd0;
                        reply_word_next  = 32'd0;
                        wait_count_next  = 16'd0;
                    end
                end
                urdc8_pkg::OP_RX_BYTE:
                begin
                    if (reply_armed_reg)
                    begin
                        if (reply_count_reg >= urdc8_pkg::REPLY_CRC_IDX)
                        begin
                            emit          = 1'b1;
                            out_kind_next = urdc8_pkg::KIND_REPLY;
                            if (in_rx_byte_reg == reply_crc_reg)
                            begin
                                out_read_data_next = reply_word_reg;
                                out_status_next    = urdc8_pkg::STATUS_OK;
                            end
                            else
                            begin
                                out_read_data_next = urdc8_pkg::ERROR_WORD;
                                out_status_next    = urdc8_pkg::STATUS_CRC_ERR;
                            end
                            reply_armed_next = 1'b0;
                            reply_count_next = 4'd0;
                        end
                        else
                        begin
                            reply_crc_next = urdc8_pkg::crc8_byte(reply_crc_reg,
                                                                  in_rx_byte_reg);
                            if (reply_count_reg >= urdc8_pkg::REPLY_DATA_START)
                            begin
                                reply_word_next = {reply_word_reg[23:0], in_rx_byte_reg};
                            end
                            reply_count_next = reply_count_reg + 4'd1;
                        end
                    end
                end
                urdc8_pkg::OP_TICK:
                begin
                    if (reply_armed_reg)
                    begin
                        wait_count_next = wait_inc;
                        if (wait_inc >= timeout_ticks_reg)
                        begin
                            emit               = 1'b1;
                            out_kind_next      = urdc8_pkg::KIND_REPLY;
                            out_read_data_next = urdc8_pkg::ERROR_WORD;
                            out_status_next    = urdc8_pkg::STATUS_TIMEOUT;
                            reply_armed_next   = 1'b0;
                            reply_count_next   = 4'd0;
                        end
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end

        if (advance)
        begin
            out_valid_next = emit;
        end
        else
        begin
            out_valid_next = out_valid_reg && !rsp.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_address_reg  <= 8'd0;
            timeout_ticks_reg <= urdc8_pkg::TIMEOUT_RESET;
            in_valid_reg      <= 1'b0;
            byte_idx_reg      <= 3'd0;
            tx_crc_reg        <= 8'd0;
            reply_armed_reg   <= 1'b0;
            reply_count_reg   <= 4'd0;
            reply_crc_reg     <= 8'd0;
            reply_word_reg    <= 32'd0;
            wait_count_reg    <= 16'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    urdc8_pkg::REG_NODE_ADDRESS:  node_address_reg  <= cfg.data[7:0];
                    urdc8_pkg::REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg.data;
                    default:                      node_address_reg  <= node_address_reg;
                endcase
            end
            in_valid_reg    <= in_valid_next;
            byte_idx_reg    <= byte_idx_next;
            tx_crc_reg      <= tx_crc_next;
            reply_armed_reg <= reply_armed_next;
            reply_count_reg <= reply_count_next;
            reply_crc_reg   <= reply_crc_next;
            reply_word_reg  <= reply_word_next;
            wait_count_reg  <= wait_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_op_reg          <= req.op;
            in_is_write_reg    <= req.is_write;
            in_reg_address_reg <= req.reg_address;
            in_write_data_reg  <= req.write_data;
            in_rx_byte_reg     <= req.rx_byte;
        end
        if (advance)
        begin
            out_kind_reg      <= out_kind_next;
            out_tx_byte_reg   <= out_tx_byte_next;
            out_last_reg      <= out_last_next;
            out_read_data_reg <= out_read_data_next;
            out_status_reg    <= out_status_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.kind      = out_kind_reg;
    assign rsp.tx_byte   = out_tx_byte_reg;
    assign rsp.last      = out_last_reg;
    assign rsp.read_data = out_read_data_reg;
    assign rsp.status    = out_status_reg;

    // a datagram in progress always sits on a held request
    a_seq_on_request: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_idx_reg != 3'd0) |-> (in_valid_reg && (in_op_reg == urdc8_pkg::OP_REQUEST)))
        else $error("datagram sequencer running without a request");

    a_reply_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        reply_count_reg <= urdc8_pkg::REPLY_CRC_IDX)
        else $error("reply byte count out of range");

    a_read_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_op_reg == urdc8_pkg::OP_REQUEST) && !in_is_write_reg
         && (byte_idx_reg == urdc8_pkg::LAST_BYTE_IDX))
        |=> (reply_armed_reg && (reply_count_reg == 4'd0) && (wait_count_reg == 16'd0)))
        else $error("read request did not arm reply reception");

    a_reply_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit && (out_kind_next == urdc8_pkg::KIND_REPLY))
        |-> (reply_armed_reg && !reply_armed_next))
        else $error("reply outcome without armed reception");

    a_last_closes_datagram: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_op_reg == urdc8_pkg::OP_REQUEST)
         && (byte_idx_reg == urdc8_pkg::LAST_BYTE_IDX)) |=> (byte_idx_reg == 3'd0))
        else $error("datagram byte index did not wrap after last byte");

endmodule

>>> bench/uart_register_datagram_crc8_unit_tb.sv
// testbench for uart_register_datagram_crc8_unit: directed and random requests, reply bytes
// and ticks, with a self-checking predictor of datagrams and reply outcomes
// depends on urdc8_pkg and the urdc8 request, result and configuration interfaces
module uart_register_datagram_crc8_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         IDLE_LIMIT = 4000;

    typedef struct packed {
        logic [1:0]  op;
        logic        is_write;
        logic [6:0]  reg_address;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } req_word_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [31:0] read_data;
        logic [1:0]  status;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    urdc8_req_if req_ch ();
    urdc8_rsp_if rsp_ch ();
    urdc8_cfg_if cfg_ch ();

    uart_register_datagram_crc8_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #4 clk = ~clk;

    req_word_t upcoming_words[$];
    result_t   awaited_results[$];

    // predictor copy of configuration and reply state
    logic [7:0]  node_addr  = 8'd0;
    logic [15:0] tick_limit = urdc8_pkg::TIMEOUT_RESET;
    logic        armed      = 1'b0;
    logic [3:0]  rx_count   = 4'd0;
    logic [7:0]  rx_crc     = 8'd0;
    logic [31:0] rx_word    = 32'd0;
    logic [15:0] tick_count = 16'd0;

    int errors = 0;
    int words_in = 0;
    int datagrams = 0;
    int replies_ok = 0;
    int replies_crc = 0;
    int replies_timeout = 0;

    function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        int k;
        c = acc ^ b;
        for (k = 0; k < 8; k++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ urdc8_pkg::CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // datagram bytes for a request, reply outcome on the eighth byte or on timeout
    function automatic void predict_datagram_and_reply(input req_word_t w);
        result_t    r;
        logic [7:0] dg [0:7];
        logic [31:0] d;
        logic [7:0] c;
        int i;
        r = '0;
        case (w.op)
            urdc8_pkg::OP_REQUEST:
            begin
                d = w.is_write ? w.write_data : 32'd0;
                dg[0] = urdc8_pkg::SYNC_BYTE;
                dg[1] = node_addr;
                dg[2] = (w.is_write ? urdc8_pkg::WRITE_FLAG : 8'h00) | {1'b0, w.reg_address};
                dg[3] = d[31:24];
                dg[4] = d[23:16];
                dg[5] = d[15:8];
                dg[6] = d[7:0];
                c = 8'd0;
                for (i = 0; i < 7; i++)
                begin
                    c = crc8_update(c, dg[i]);
                end
                dg[7] = c;
                for (i = 0; i < 8; i++)
                begin
                    r = '0;
                    r.kind = urdc8_pkg::KIND_TX;
                    r.tx_byte = dg[i];
                    r.last = (i == 7);
                    awaited_results.push_back(r);
                end
                if (!w.is_write)
                begin
                    armed = 1'b1;
                    rx_count = 4'd0;
                    rx_crc = 8'd0;
                    rx_word = 32'd0;
                    tick_count = 16'd0;
                end
            end
            urdc8_pkg::OP_RX_BYTE:
            begin
                if (armed)
                begin
                    if (rx_count >= urdc8_pkg::REPLY_CRC_IDX)
                    begin
                        r.kind = urdc8_pkg::KIND_REPLY;
                        r.read_data = (w.rx_byte == rx_crc) ? rx_word
                                                            : urdc8_pkg::ERROR_WORD;
                        r.status = (w.rx_byte == rx_crc) ? urdc8_pkg::STATUS_OK
                                                         : urdc8_pkg::STATUS_CRC_ERR;
                        awaited_results.push_back(r);
                        armed = 1'b0;
                        rx_count = 4'd0;
                    end
                    else
                    begin
                        rx_crc = crc8_update(rx_crc, w.rx_byte);
                        if (rx_count >= urdc8_pkg::REPLY_DATA_START)
                        begin
                            rx_word = {rx_word[23:0], w.rx_byte};
                        end
                        rx_count = rx_count + 4'd1;
                    end
                end
            end
            urdc8_pkg::OP_TICK:
            begin
                if (armed)
                begin
                    if (tick_count < urdc8_pkg::WAIT_MAX)
                    begin
                        tick_count = tick_count + 16'd1;
                    end
                    if (tick_count >= tick_limit)
                    begin
                        r.kind = urdc8_pkg::KIND_REPLY;
                        r.read_data = urdc8_pkg::ERROR_WORD;
                        r.status = urdc8_pkg::STATUS_TIMEOUT;
                        awaited_results.push_back(r);
                        armed = 1'b0;
                        rx_count = 4'd0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void push_word(input logic [1:0] op, input logic wr,
                                      input logic [6:0] ra, input logic [31:0] wd,
                                      input logic [7:0] rx);
        req_word_t w;
        w.op = op;
        w.is_write = wr;
        w.reg_address = ra;
        w.write_data = wd;
        w.rx_byte = rx;
        upcoming_words.push_back(w);
    endfunction

    function automatic void request_word(input logic wr, input logic [6:0] ra,
                                         input logic [31:0] wd);
        push_word(urdc8_pkg::OP_REQUEST, wr, ra, wd, 8'($urandom_range(0, 255)));
    endfunction

    function automatic void rx_byte_word(input logic [7:0] b);
        push_word(urdc8_pkg::OP_RX_BYTE, 1'($urandom_range(0, 1)),
                  7'($urandom_range(0, 127)), $urandom, b);
    endfunction

    function automatic void tick_word();
        push_word(urdc8_pkg::OP_TICK, 1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                  $urandom, 8'($urandom_range(0, 255)));
    endfunction

    // reply of eight bytes (or the first nb of them); noisy mixes in ticks and writes
    function automatic void push_reply(input logic [31:0] value, input bit good, input int nb,
                                       input bit noisy);
        logic [7:0] bytes [0:7];
        logic [7:0] c;
        int i;
        for (i = 0; i < 3; i++)
        begin
            bytes[i] = 8'($urandom_range(0, 255));
        end
        bytes[3] = value[31:24];
        bytes[4] = value[23:16];
        bytes[5] = value[15:8];
        bytes[6] = value[7:0];
        c = 8'd0;
        for (i = 0; i < 7; i++)
        begin
            c = crc8_update(c, bytes[i]);
        end
        bytes[7] = good ? c : (c ^ (8'h01 << $urandom_range(0, 7)));
        for (i = 0; i < nb; i++)
        begin
            if (noisy && $urandom_range(0, 6) == 0)
            begin
                tick_word();
            end
            if (noisy && $urandom_range(0, 24) == 0)
            begin
                request_word(1'b1, 7'($urandom_range(0, 127)), $urandom);
            end
            rx_byte_word(bytes[i]);
        end
    endfunction

    function automatic void random_traffic(input int target);
        int count;
        int roll;
        int nb;
        int k;
        count = 0;
        while (count < target)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
            begin
                request_word(1'b0, 7'($urandom_range(0, 127)), $urandom);
                nb = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 7) : 8;
                push_reply($urandom, $urandom_range(0, 3) != 0, nb, 1'b1);
                count += nb + 1;
            end
            else if (roll < 70)
            begin
                request_word(1'b1, 7'($urandom_range(0, 127)), $urandom);
                count++;
            end
            else if (roll < 88)
            begin
                nb = $urandom_range(1, 12);
                for (k = 0; k < nb; k++)
                begin
                    tick_word();
                end
                count += nb;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: rx_byte_word(8'($urandom_range(0, 255)));
                    1: tick_word();
                    default: push_word(OP_UNUSED, 1'($urandom_range(0, 1)),
                                       7'($urandom_range(0, 127)), $urandom,
                                       8'($urandom_range(0, 255)));
                endcase
                count++;
            end
        end
    endfunction

    function automatic int next_gap(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch in %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // request driver
    req_word_t cur_word;
    int        send_gap = 0;
    int        send_calm = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_datagram_and_reply(cur_word);
                words_in++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (upcoming_words.size() > 0)
                begin
                    cur_word = upcoming_words.pop_front();
                    req_ch.op <= cur_word.op;
                    req_ch.is_write <= cur_word.is_write;
                    req_ch.reg_address <= cur_word.reg_address;
                    req_ch.write_data <= cur_word.write_data;
                    req_ch.rx_byte <= cur_word.rx_byte;
                    req_ch.valid <= 1'b1;
                    send_gap = next_gap(send_calm);
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random backpressure
    int      recv_hold = 0;
    int      recv_calm = 0;
    result_t got_res;
    result_t want_res;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            recv_hold = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got_res = {rsp_ch.kind, rsp_ch.tx_byte, rsp_ch.last, rsp_ch.read_data,
                           rsp_ch.status};
                if (got_res.kind === urdc8_pkg::KIND_TX && got_res.last === 1'b1)
                begin
                    datagrams++;
                end
                else if (got_res.kind === urdc8_pkg::KIND_REPLY)
                begin
                    case (got_res.status)
                        urdc8_pkg::STATUS_OK:      replies_ok++;
                        urdc8_pkg::STATUS_CRC_ERR: replies_crc++;
                        default:                   replies_timeout++;
                    endcase
                end
                if (awaited_results.size() == 0)
                begin
                    note_mismatch("unexpected result word", got_res[43:12], 32'd0);
                end
                else
                begin
                    want_res = awaited_results.pop_front();
                    if (got_res.kind !== want_res.kind)
                        note_mismatch("kind", 32'(got_res.kind), 32'(want_res.kind));
                    if (got_res.tx_byte !== want_res.tx_byte)
                        note_mismatch("tx_byte", 32'(got_res.tx_byte), 32'(want_res.tx_byte));
                    if (got_res.last !== want_res.last)
                        note_mismatch("last", 32'(got_res.last), 32'(want_res.last));
                    if (got_res.read_data !== want_res.read_data)
                        note_mismatch("read_data", got_res.read_data, want_res.read_data);
                    if (got_res.status !== want_res.status)
                        note_mismatch("status", 32'(got_res.status), 32'(want_res.status));
                end
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                recv_hold = next_gap(recv_calm);
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog expired with %0d results outstanding",
                         awaited_results.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic write_register(input logic idx, input logic [15:0] value);
        @(posedge clk);
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == urdc8_pkg::REG_NODE_ADDRESS)
        begin
            node_addr = value[7:0];
        end
        else
        begin
            tick_limit = value;
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // wait for all words to drain, then let an ignored word leave the pipeline
    task automatic settle();
        while (upcoming_words.size() != 0 || req_ch.valid || awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.op = urdc8_pkg::OP_REQUEST;
        req_ch.is_write = 1'b0;
        req_ch.reg_address = 7'd0;
        req_ch.write_data = 32'd0;
        req_ch.rx_byte = 8'd0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = urdc8_pkg::REG_NODE_ADDRESS;
        cfg_ch.data = 16'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: extremes, read data forced to zero, ignored words,
        // restarted read, write during reply, good and bad crc
        request_word(1'b1, 7'd0, 32'd0);
        request_word(1'b1, 7'd127, 32'hFFFF_FFFF);
        request_word(1'b0, 7'h2A, 32'hDEAD_BEEF);
        tick_word();
        push_reply(32'h8000_0001, 1'b1, 8, 1'b0);
        rx_byte_word(8'hFF);
        tick_word();
        push_word(OP_UNUSED, 1'b1, 7'h7F, 32'hFFFF_FFFF, 8'hFF);
        request_word(1'b0, 7'h7F, 32'h0);
        request_word(1'b0, 7'h01, 32'h5555_AAAA);
        request_word(1'b1, 7'h40, 32'h1234_5678);
        push_reply(32'hFFFF_FFFF, 1'b0, 8, 1'b0);
        settle();

        // shortest timeout and full node address
        write_register(urdc8_pkg::REG_NODE_ADDRESS, {8'($urandom_range(0, 255)), 8'hFF});
        write_register(urdc8_pkg::REG_TIMEOUT_TICKS, 16'd1);
        request_word(1'b0, 7'h33, 32'h0);
        tick_word();
        rx_byte_word(8'h00);
        request_word(1'b0, 7'h0C, 32'h0);
        push_reply(32'h0000_0000, 1'b1, 8, 1'b0);
        random_traffic(20);
        settle();

        // longest timeout
        write_register(urdc8_pkg::REG_NODE_ADDRESS, 16'($urandom_range(0, 65535)));
        write_register(urdc8_pkg::REG_TIMEOUT_TICKS, 16'hFFFF);
        random_traffic(20);
        settle();

        // short timeout so that tick bursts expire
        write_register(urdc8_pkg::REG_NODE_ADDRESS, 16'h0000);
        write_register(urdc8_pkg::REG_TIMEOUT_TICKS, 16'($urandom_range(2, 12)));
        random_traffic(20);
        settle();

        repeat (20) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            note_mismatch("missing results", 32'd0, 32'(awaited_results.size()));
        end
        $display("%0d input words sent, %0d datagrams checked", words_in, datagrams);
        $display("reply outcomes: %0d good, %0d crc errors, %0d timeouts",
                 replies_ok, replies_crc, replies_timeout);
        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
